// ===== hdl/stto_pkg.sv =====
// Shared types, widths and constants of the sphere-triangle overlap test.
package stto_pkg;

    // Coordinate format and default fraction width.
    localparam int COORD_W       = 24;
    localparam int FRAC_BITS_DEF = 8;

    // Widths of the exact intermediate values.
    localparam int DW = COORD_W + 1;     // vertex differences
    localparam int PW = 2 * DW + 2;      // dot products
    localparam int NW = 2 * DW + 1;      // normal components
    localparam int QW = 2 * PW + 1;      // determinant and barycentric numerators
    localparam int SW = DW + NW + 2;     // centre offset dotted with the normal

    // Operand slice of the partial-product multipliers.
    localparam int MUL_CHUNK = 26;

    // Radius reset value, 1.0 m in Q8.8.
    localparam logic [15:0] RADIUS_RST = 16'd256;

    // 10^8 / 2^8, the divisor of the 1e-8 thresholds once scaled to the format.
    localparam longint unsigned EPS_DIV = 64'd390625;

    // Contact classification.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_FACE = 2'd1,
        KIND_EDGE = 2'd2
    } t_kind;

    // Input transaction: sphere centre and triangle vertices.
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic signed [COORD_W-1:0] vertex_a_x;
        logic signed [COORD_W-1:0] vertex_a_y;
        logic signed [COORD_W-1:0] vertex_a_z;
        logic signed [COORD_W-1:0] vertex_b_x;
        logic signed [COORD_W-1:0] vertex_b_y;
        logic signed [COORD_W-1:0] vertex_b_z;
        logic signed [COORD_W-1:0] vertex_c_x;
        logic signed [COORD_W-1:0] vertex_c_y;
        logic signed [COORD_W-1:0] vertex_c_z;
    } t_in;

    // Output transaction.
    typedef struct packed {
        logic  overlap;
        t_kind contact_kind;
    } t_out;

    // Early decisions of one edge test, carried down its pipeline.
    typedef struct packed {
        logic len_tiny;
        logic t_nonpos;
        logic t_past_end;
        logic start_hit;
        logic end_hit;
    } t_edge_flags;

endpackage

// ===== hdl/stto_dly.sv =====
// Enabled delay line of fixed depth.
module stto_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_pipe [D];

    // Shift the line when the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[D-1];
endmodule

// ===== hdl/stto_mul.sv =====
// Signed multiplier built from registered partial products.
module stto_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [WA-1:0]  i_a,
    input  logic signed [WB-1:0]  i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import stto_pkg::*;

    localparam int CH  = MUL_CHUNK;
    localparam int NA  = (WA + CH - 1) / CH;
    localparam int NB  = (WB + CH - 1) / CH;
    localparam int FW  = (NA + NB) * CH + 2;
    localparam int PPW = 2 * CH + 2;

    logic signed [NA*CH-1:0] a_ext;
    logic signed [NB*CH-1:0] b_ext;
    logic signed [CH:0]      a_ch [NA];
    logic signed [CH:0]      b_ch [NB];
    logic signed [PPW-1:0]   r_pp [NA][NB];
    logic signed [FW-1:0]    n_row [NA];
    logic signed [FW-1:0]    r_row [NA];
    logic signed [FW-1:0]    n_sum;
    logic signed [WA+WB-1:0] r_p;

    assign a_ext = (NA*CH)'(i_a);
    assign b_ext = (NB*CH)'(i_b);

    // Split the operands: lower slices unsigned, the top slice carries the sign.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                a_ch[i] = {a_ext[NA*CH-1], a_ext[i*CH +: CH]};
            end else begin
                a_ch[i] = {1'b0, a_ext[i*CH +: CH]};
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                b_ch[j] = {b_ext[NB*CH-1], b_ext[j*CH +: CH]};
            end else begin
                b_ch[j] = {1'b0, b_ext[j*CH +: CH]};
            end
        end
    end

    // First level: slice products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= PPW'(a_ch[i] * b_ch[j]);
                end
            end
        end
    end

    // Second level: one row per slice of the first operand.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (FW'(r_pp[i][j]) <<< (j * CH));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
        end
    end

    // Third level: rows added into the full product.
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (r_row[i] <<< (i * CH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_sum[WA+WB-1:0];
        end
    end

    assign o_p = r_p;
endmodule

// ===== hdl/stto_edge.sv =====
// Squared distance test of the sphere centre against one triangle edge.
module stto_edge #(
    parameter int FRAC_BITS = stto_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [stto_pkg::PW-1:0]  i_len,
    input  logic signed [stto_pkg::PW-1:0]  i_t,
    input  logic signed [stto_pkg::PW-1:0]  i_ps2,
    input  logic signed [stto_pkg::PW-1:0]  i_pe2,
    input  logic [2*(8+FRAC_BITS)-1:0]      i_rc2,
    output logic                            o_hit
);
    import stto_pkg::*;

    localparam int RC2W = 2 * (8 + FRAC_BITS);
    localparam int CW   = ((PW > RC2W) ? PW : RC2W) + 1;
    localparam int DFW  = 2 * PW + 1;
    localparam int RLW  = RC2W + 1 + PW;
    localparam int CW2  = ((DFW > RLW) ? DFW : RLW) + 1;
    localparam longint unsigned LMIN =
        ((64'd1 << (2 * FRAC_BITS - 8)) + EPS_DIV - 64'd1) / EPS_DIV;

    logic signed [CW-1:0]      rc2_s;
    logic signed [RC2W:0]      rc2_op;
    t_edge_flags               r_flg;
    t_edge_flags               flg8;
    logic [$bits(t_edge_flags)-1:0] flg_dly;
    logic signed [2*PW-1:0]    pl;
    logic signed [2*PW-1:0]    tt;
    logic signed [RLW-1:0]     rl;
    logic signed [DFW-1:0]     r_diff;
    logic signed [RLW-1:0]     r_rl;
    logic                      r_hit;

    assign rc2_s  = CW'({1'b0, i_rc2});
    assign rc2_op = {1'b0, i_rc2};

    // Early decisions: short edge, projection before the start or past the end, endpoint hits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flg.len_tiny   <= i_len < $signed(PW'(LMIN));
            r_flg.t_nonpos   <= i_t <= 0;
            r_flg.t_past_end <= i_len <= i_t;
            r_flg.start_hit  <= CW'(i_ps2) <= rc2_s;
            r_flg.end_hit    <= CW'(i_pe2) <= rc2_s;
        end
    end

    stto_dly #(.W($bits(t_edge_flags)), .D(3)) u_flg_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_flg),
        .o_q   (flg_dly)
    );
    assign flg8 = t_edge_flags'(flg_dly);

    // Products for the interior case: |c-S|^2 * L, t^2 and rc^2 * L.
    stto_mul #(.WA(PW), .WB(PW)) u_pl (
        .i_clk (i_clk), .i_en (i_en), .i_a (i_ps2), .i_b (i_len), .o_p (pl)
    );
    stto_mul #(.WA(PW), .WB(PW)) u_tt (
        .i_clk (i_clk), .i_en (i_en), .i_a (i_t), .i_b (i_t), .o_p (tt)
    );
    stto_mul #(.WA(RC2W + 1), .WB(PW)) u_rl (
        .i_clk (i_clk), .i_en (i_en), .i_a (rc2_op), .i_b (i_len), .o_p (rl)
    );

    // Perpendicular distance numerator.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= DFW'(pl) - DFW'(tt);
            r_rl   <= rl;
        end
    end

    // Pick the distance that applies to this edge.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            priority if (flg8.len_tiny || flg8.t_nonpos) begin
                r_hit <= flg8.start_hit;
            end else if (flg8.t_past_end) begin
                r_hit <= flg8.end_hit;
            end else begin
                r_hit <= CW2'(r_diff) <= CW2'(r_rl);
            end
        end
    end

    assign o_hit = r_hit;
endmodule

// ===== hdl/sphere_triangle_overlap_test.sv =====
// The pipeline has 13 register stages, the input register first.
// Throughput: one transaction per cycle while the output is not stalled; the multipliers
// are split into registered partial products, so every stage of the pipeline takes a new
// item each cycle unless a stalled output holds it.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets the radius to 1.0 m.
module sphere_triangle_overlap_test #(
    parameter int FRAC_BITS = stto_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  stto_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output stto_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import stto_pkg::*;

    localparam int NSTG = 13;
    localparam int RW   = 8 + FRAC_BITS;
    localparam int RC2W = 2 * RW;
    localparam int BW   = ((COORD_W > RW) ? COORD_W : RW) + 2;
    localparam int UW   = QW + 2;
    localparam int TW   = UW + 14;
    localparam int RDW  = RC2W + 1 + QW;
    localparam int CMPW = ((2 * SW > RDW) ? 2 * SW : RDW) + 1;
    localparam longint unsigned DMIN =
        ((64'd1 << (4 * FRAC_BITS - 8)) + EPS_DIV - 64'd1) / EPS_DIV;

    // Difference vectors: E1=B-A, E2=C-A, BC=C-B, CA=A-C, PA=P-A, PB=P-B, PC=P-C.
    localparam int NVEC = 7;
    localparam int V_E1 = 0, V_E2 = 1, V_BC = 2, V_CA = 3, V_PA = 4, V_PB = 5, V_PC = 6;
    localparam int VEC_HEAD [NVEC] = '{2, 3, 3, 1, 0, 0, 0};
    localparam int VEC_TAIL [NVEC] = '{1, 1, 2, 3, 1, 2, 3};

    // Dot products used by the face and edge tests.
    localparam int NDOT = 11;
    localparam int D00 = 0, D01 = 1, D11 = 2, D20 = 3, D21 = 4, DPA = 5;
    localparam int DLBC = 6, DTBC = 7, DPB = 8, DTCA = 9, DPC = 10;
    localparam int DOT_A [NDOT] = '{V_E1, V_E1, V_E2, V_PA, V_PA, V_PA,
                                    V_BC, V_PB, V_PB, V_PC, V_PC};
    localparam int DOT_B [NDOT] = '{V_E1, V_E2, V_E2, V_E1, V_E2, V_PA,
                                    V_BC, V_BC, V_PB, V_CA, V_PC};

    logic                      en;
    logic [NSTG-1:0]           r_vld;
    logic [15:0]               r_radius;
    logic [15+FRAC_BITS:0]     rad_sh;
    logic [RW-1:0]             rc;
    logic [RC2W-1:0]           r_rc2;

    t_in                       r_s1;
    logic signed [COORD_W-1:0] pt [4][3];
    logic signed [DW-1:0]      r_vec [NVEC][3];
    logic signed [COORD_W-1:0] r_mn [3];
    logic signed [COORD_W-1:0] r_mx [3];
    logic signed [COORD_W-1:0] r_ctr [3];
    logic                      r_rej3;
    logic signed [2*DW-1:0]    r_pp [NDOT][3];
    logic signed [2*DW-1:0]    r_xp [6];
    logic signed [PW-1:0]      r_dot [NDOT];
    logic signed [NW-1:0]      r_nrm [3];
    logic [3*DW-1:0]           pa4_bits;
    logic signed [DW-1:0]      pa4 [3];

    logic signed [2*PW-1:0]    m_dd, m_0101, m_1120, m_0121, m_0021, m_0120;
    logic signed [DW+NW-1:0]   m_s [3];
    logic signed [QW-1:0]      r_den8, r_v8, r_w8;
    logic signed [SW-1:0]      r_s8;
    logic signed [UW-1:0]      r_u9, r_v9, r_w9;
    logic signed [QW-1:0]      r_den9, r_den10;
    logic                      r_dok9, r_dok10, r_in11;
    logic signed [TW-1:0]      r_tu10, r_tv10, r_tw10;
    logic signed [TW:0]        sum_u, sum_v, sum_w;
    logic signed [2*SW-1:0]    m_ss;
    logic signed [RC2W:0]      rc2_op;
    logic signed [RDW-1:0]     m_rd;
    logic                      r_face12;
    logic                      rej12;
    logic [2:0]                hit9;
    logic [2:0]                hit12;
    t_out                      r_out;

    // The pipeline advances unless a finished result is waiting and the output is not ready.
    assign en          = ~r_vld[NSTG-1] | i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // Radius register and its aligned square.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    assign rad_sh = {r_radius, {FRAC_BITS{1'b0}}};
    assign rc     = rad_sh[15+FRAC_BITS:8];

    always_ff @(posedge i_clk) begin
        r_rc2 <= rc * rc;
    end

    // Stage 1: input register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_in_data;
        end
    end

    always_comb begin
        pt[0][0] = r_s1.center_x;   pt[0][1] = r_s1.center_y;   pt[0][2] = r_s1.center_z;
        pt[1][0] = r_s1.vertex_a_x; pt[1][1] = r_s1.vertex_a_y; pt[1][2] = r_s1.vertex_a_z;
        pt[2][0] = r_s1.vertex_b_x; pt[2][1] = r_s1.vertex_b_y; pt[2][2] = r_s1.vertex_b_z;
        pt[3][0] = r_s1.vertex_c_x; pt[3][1] = r_s1.vertex_c_y; pt[3][2] = r_s1.vertex_c_z;
    end

    function automatic logic signed [COORD_W-1:0] min3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic logic signed [COORD_W-1:0] max3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    // Stage 2: difference vectors and the triangle's bounding box.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < NVEC; v++) begin
                for (int k = 0; k < 3; k++) begin
                    r_vec[v][k] <= DW'(pt[VEC_HEAD[v]][k]) - DW'(pt[VEC_TAIL[v]][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_mn[k]  <= min3(pt[1][k], pt[2][k], pt[3][k]);
                r_mx[k]  <= max3(pt[1][k], pt[2][k], pt[3][k]);
                r_ctr[k] <= pt[0][k];
            end
        end
    end

    // Stage 3: box reject, dot and cross product terms.
    always_ff @(posedge i_clk) begin
        logic rej;
        logic signed [BW-1:0] rc_s;
        rej  = 1'b0;
        rc_s = BW'({1'b0, rc});
        for (int k = 0; k < 3; k++) begin
            if (BW'(r_ctr[k]) < BW'(r_mn[k]) - rc_s || BW'(r_ctr[k]) > BW'(r_mx[k]) + rc_s) begin
                rej = 1'b1;
            end
        end
        if (en) begin
            r_rej3 <= rej;
            for (int d = 0; d < NDOT; d++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pp[d][k] <= r_vec[DOT_A[d]][k] * r_vec[DOT_B[d]][k];
                end
            end
            r_xp[0] <= r_vec[V_E1][1] * r_vec[V_E2][2];
            r_xp[1] <= r_vec[V_E1][2] * r_vec[V_E2][1];
            r_xp[2] <= r_vec[V_E1][2] * r_vec[V_E2][0];
            r_xp[3] <= r_vec[V_E1][0] * r_vec[V_E2][2];
            r_xp[4] <= r_vec[V_E1][0] * r_vec[V_E2][1];
            r_xp[5] <= r_vec[V_E1][1] * r_vec[V_E2][0];
        end
    end

    // Stage 4: dot product sums and the plane normal.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < NDOT; d++) begin
                r_dot[d] <= PW'(r_pp[d][0]) + PW'(r_pp[d][1]) + PW'(r_pp[d][2]);
            end
            for (int k = 0; k < 3; k++) begin
                r_nrm[k] <= NW'(r_xp[2*k]) - NW'(r_xp[2*k+1]);
            end
        end
    end

    // Centre offset from A, brought alongside the normal.
    stto_dly #(.W(3 * DW), .D(2)) u_pa_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_vec[V_PA][0], r_vec[V_PA][1], r_vec[V_PA][2]}),
        .o_q   (pa4_bits)
    );
    assign pa4[0] = pa4_bits[3*DW-1:2*DW];
    assign pa4[1] = pa4_bits[2*DW-1:DW];
    assign pa4[2] = pa4_bits[DW-1:0];

    // Stages 5 to 7: determinant, barycentric and plane distance products.
    stto_mul #(.WA(PW), .WB(PW)) u_m_dd (
        .i_clk (i_clk), .i_en (en), .i_a (r_dot[D00]), .i_b (r_dot[D11]), .o_p (m_dd)
    );
    stto_mul #(.WA(PW), .WB(PW)) u_m_0101 (
        .i_clk (i_clk), .i_en (en), .i_a (r_dot[D01]), .i_b (r_dot[D01]), .o_p (m_0101)
    );
    stto_mul #(.WA(PW), .WB(PW)) u_m_1120 (
        .i_clk (i_clk), .i_en (en), .i_a (r_dot[D11]), .i_b (r_dot[D20]), .o_p (m_1120)
    );
    stto_mul #(.WA(PW), .WB(PW)) u_m_0121 (
        .i_clk (i_clk), .i_en (en), .i_a (r_dot[D01]), .i_b (r_dot[D21]), .o_p (m_0121)
    );
    stto_mul #(.WA(PW), .WB(PW)) u_m_0021 (
        .i_clk (i_clk), .i_en (en), .i_a (r_dot[D00]), .i_b (r_dot[D21]), .o_p (m_0021)
    );
    stto_mul #(.WA(PW), .WB(PW)) u_m_0120 (
        .i_clk (i_clk), .i_en (en), .i_a (r_dot[D01]), .i_b (r_dot[D20]), .o_p (m_0120)
    );

    for (genvar k = 0; k < 3; k++) begin : g_plane
        stto_mul #(.WA(DW), .WB(NW)) u_m_s (
            .i_clk (i_clk), .i_en (en), .i_a (pa4[k]), .i_b (r_nrm[k]), .o_p (m_s[k])
        );
    end

    // Stage 8: determinant, barycentric numerators, plane offset.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den8 <= QW'(m_dd) - QW'(m_0101);
            r_v8   <= QW'(m_1120) - QW'(m_0121);
            r_w8   <= QW'(m_0021) - QW'(m_0120);
            r_s8   <= SW'(m_s[0]) + SW'(m_s[1]) + SW'(m_s[2]);
        end
    end

    // Stages 9 to 11: squared plane offset and radius-scaled determinant.
    stto_mul #(.WA(SW), .WB(SW)) u_m_ss (
        .i_clk (i_clk), .i_en (en), .i_a (r_s8), .i_b (r_s8), .o_p (m_ss)
    );
    assign rc2_op = {1'b0, r_rc2};
    stto_mul #(.WA(RC2W + 1), .WB(QW)) u_m_rd (
        .i_clk (i_clk), .i_en (en), .i_a (rc2_op), .i_b (r_den8), .o_p (m_rd)
    );

    // Stage 9: third barycentric numerator and the degenerate triangle check.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u9   <= UW'(r_den8) - UW'(r_v8) - UW'(r_w8);
            r_v9   <= UW'(r_v8);
            r_w9   <= UW'(r_w8);
            r_den9 <= r_den8;
            r_dok9 <= r_den8 >= $signed(QW'(DMIN));
        end
    end

    // Scale by the inverse tolerance, 10000 as a sum of shifts.
    function automatic logic signed [TW-1:0] times_10k(input logic signed [UW-1:0] x);
        logic signed [TW-1:0] e;
        e = TW'(x);
        return (e <<< 13) + (e <<< 10) + (e <<< 9) + (e <<< 8) + (e <<< 4);
    endfunction

    // Stage 10: scaled barycentric numerators.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tu10  <= times_10k(r_u9);
            r_tv10  <= times_10k(r_v9);
            r_tw10  <= times_10k(r_w9);
            r_den10 <= r_den9;
            r_dok10 <= r_dok9;
        end
    end

    // Stage 11: inside test with tolerance.
    assign sum_u = (TW+1)'(r_tu10) + (TW+1)'(r_den10);
    assign sum_v = (TW+1)'(r_tv10) + (TW+1)'(r_den10);
    assign sum_w = (TW+1)'(r_tw10) + (TW+1)'(r_den10);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in11 <= r_dok10 & ~sum_u[TW] & ~sum_v[TW] & ~sum_w[TW];
        end
    end

    // Stage 12: face contact when inside and close enough to the plane.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_face12 <= r_in11 & (CMPW'(m_ss) <= CMPW'(m_rd));
        end
    end

    // Edge tests, results at stage 9.
    stto_edge #(.FRAC_BITS(FRAC_BITS)) u_edge_ab (
        .i_clk (i_clk), .i_en (en),
        .i_len (r_dot[D00]), .i_t (r_dot[D20]), .i_ps2 (r_dot[DPA]), .i_pe2 (r_dot[DPB]),
        .i_rc2 (r_rc2), .o_hit (hit9[0])
    );
    stto_edge #(.FRAC_BITS(FRAC_BITS)) u_edge_bc (
        .i_clk (i_clk), .i_en (en),
        .i_len (r_dot[DLBC]), .i_t (r_dot[DTBC]), .i_ps2 (r_dot[DPB]), .i_pe2 (r_dot[DPC]),
        .i_rc2 (r_rc2), .o_hit (hit9[1])
    );
    stto_edge #(.FRAC_BITS(FRAC_BITS)) u_edge_ca (
        .i_clk (i_clk), .i_en (en),
        .i_len (r_dot[D11]), .i_t (r_dot[DTCA]), .i_ps2 (r_dot[DPC]), .i_pe2 (r_dot[DPA]),
        .i_rc2 (r_rc2), .o_hit (hit9[2])
    );

    stto_dly #(.W(3), .D(3)) u_hit_dly (
        .i_clk (i_clk), .i_en (en), .i_d (hit9), .o_q (hit12)
    );
    stto_dly #(.W(1), .D(9)) u_rej_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r_rej3), .o_q (rej12)
    );

    // Stage 13: classification; face contact wins over edge contact.
    always_ff @(posedge i_clk) begin
        if (en) begin
            priority if (rej12) begin
                r_out.overlap      <= 1'b0;
                r_out.contact_kind <= KIND_NONE;
            end else if (r_face12) begin
                r_out.overlap      <= 1'b1;
                r_out.contact_kind <= KIND_FACE;
            end else if (|hit12) begin
                r_out.overlap      <= 1'b1;
                r_out.contact_kind <= KIND_EDGE;
            end else begin
                r_out.overlap      <= 1'b0;
                r_out.contact_kind <= KIND_NONE;
            end
        end
    end
endmodule

// ===== hdl/stto_chk.sv =====
// Port-level checks of the overlap test, bound to the top level.
module stto_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input stto_pkg::t_out o_out_data
);
    import stto_pkg::*;

    // A waiting result holds its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // The overlap flag agrees with the contact kind.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.overlap == (o_out_data.contact_kind != KIND_NONE))
        else $error("overlap flag disagrees with contact kind");

    // A stalled output stops new input transactions.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    // No result right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind sphere_triangle_overlap_test stto_chk u_stto_chk (.*);
